### sv/gbfp_pkg.sv
// Package for the binary GNSS frame parser: status codes, size defaults and
// the reflected CRC-32 byte update. No dependencies.
package gbfp_pkg;

  localparam int unsigned MAX_HEADER_DEF  = 32;
  localparam int unsigned MAX_PAYLOAD_DEF = 256;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_LOW24 = 32'h00FF_FFFF;

  typedef enum logic [1:0] {
    ST_CRC_OK   = 2'd0,
    ST_CRC_BAD  = 2'd1,
    ST_HDR_OVF  = 2'd2,
    ST_PAY_OVF  = 2'd3
  } status_e;

  // One byte of a reflected CRC-32 with no final inversion.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = {24'h0, crc[7:0] ^ b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return ((crc >> 8) & CRC_LOW24) ^ c;
  endfunction

  // Running CRC after the first one, two and three sync bytes.
  localparam logic [31:0] CRC_SYNC1 = crc_byte(32'h0, 8'hAA);
  localparam logic [31:0] CRC_SYNC2 = crc_byte(CRC_SYNC1, 8'h44);
  localparam logic [31:0] CRC_SYNC3 = crc_byte(CRC_SYNC2, 8'h12);

endpackage

### sv/gbfp_if.sv
// Channel interfaces of the frame parser: the received byte stream and the
// result stream. Depends on gbfp_pkg.
interface gbfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface gbfp_res_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [7:0]        payload_byte;
  logic [7:0]        payload_index;
  gbfp_pkg::status_e status;
  logic [15:0]       message_id;
  logic [15:0]       message_length;
  logic [15:0]       gps_week;
  logic [31:0]       gps_ms;
  logic [31:0]       crc_errors;
  logic              last;

  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output status, output message_id, output message_length,
                  output gps_week, output gps_ms, output crc_errors, output last,
                  input ready);
  modport sink (input valid, input kind, input payload_byte, input payload_index,
                input status, input message_id, input message_length,
                input gps_week, input gps_ms, input crc_errors, input last,
                output ready);
endinterface

### sv/gnss_binary_frame_parser_crc32_core.sv
// Top level of the binary GNSS frame parser with CRC-32 check.
// Depends on gbfp_pkg and the interfaces in gbfp_if.sv.

// The parser takes one received byte per clock unless the downstream stalls:
// the sync hunt, header capture and a fully unrolled CRC-32 byte update all
// settle combinationally between the parser state and the result register.
// A result (payload byte or frame end report) appears in the result register
// on the cycle after its byte is accepted. The byte input is ready
// whenever the result register is empty or is being taken in the same cycle,
// so a downstream stall is the only thing that holds the input off.
module gnss_binary_frame_parser_crc32_core #(
  parameter int unsigned MAX_HEADER  = gbfp_pkg::MAX_HEADER_DEF,
  parameter int unsigned MAX_PAYLOAD = gbfp_pkg::MAX_PAYLOAD_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  gbfp_byte_if.sink   in_i,
  gbfp_res_if.source  out_o
);
  import gbfp_pkg::*;

  typedef enum logic [3:0] {
    PH_SYNC1  = 4'd0,
    PH_SYNC2  = 4'd1,
    PH_SYNC3  = 4'd2,
    PH_HLEN   = 4'd3,
    PH_HEADER = 4'd4,
    PH_DATA   = 4'd5,
    PH_CRC1   = 4'd6,
    PH_CRC2   = 4'd7,
    PH_CRC3   = 4'd8,
    PH_CRC4   = 4'd9
  } phase_e;

  localparam logic [7:0] SYNC_A = 8'hAA;
  localparam logic [7:0] SYNC_B = 8'h44;
  localparam logic [7:0] SYNC_C = 8'h12;

  localparam logic [15:0] POS_FIRST = 16'd4;
  localparam logic [15:0] POS_ID0   = 16'd4;
  localparam logic [15:0] POS_ID1   = 16'd5;
  localparam logic [15:0] POS_LEN0  = 16'd8;
  localparam logic [15:0] POS_LEN1  = 16'd9;
  localparam logic [15:0] POS_WK0   = 16'd14;
  localparam logic [15:0] POS_WK1   = 16'd15;
  localparam logic [15:0] POS_MS0   = 16'd16;
  localparam logic [15:0] POS_MS1   = 16'd17;
  localparam logic [15:0] POS_MS2   = 16'd18;
  localparam logic [15:0] POS_MS3   = 16'd19;

  localparam logic [15:0] HDR_LIMIT = 16'(MAX_HEADER);
  localparam logic [16:0] PAY_LIMIT = 17'(MAX_PAYLOAD);

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  hlen_q, hlen_d;
  logic [15:0] id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [15:0] week_q, week_d;
  logic [31:0] tow_q, tow_d;
  logic [31:0] crc_q, crc_d;
  logic [23:0] rx_q, rx_d;
  logic [31:0] err_q, err_d;

  logic        ovalid_q;
  logic        okind_q;
  logic [7:0]  obyte_q;
  logic [7:0]  oidx_q;
  status_e     ostat_q;
  logic [15:0] oid_q;
  logic [15:0] olen_q;
  logic [15:0] oweek_q;
  logic [31:0] otow_q;
  logic [31:0] oerr_q;

  logic        accept;
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_byte;
  logic [7:0]  res_idx;
  status_e     res_stat;
  logic [15:0] cnt_inc;
  logic [7:0]  b;

  assign b        = in_i.byte_in;
  assign in_i.ready = !ovalid_q || out_o.ready;
  assign accept   = in_i.valid && in_i.ready;
  assign cnt_inc  = cnt_q + 16'd1;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    hlen_d    = hlen_q;
    id_d      = id_q;
    len_d     = len_q;
    week_d    = week_q;
    tow_d     = tow_q;
    crc_d     = crc_q;
    rx_d      = rx_q;
    err_d     = err_q;
    res_valid = 1'b0;
    res_kind  = 1'b0;
    res_byte  = 8'h00;
    res_idx   = 8'h00;
    res_stat  = ST_CRC_OK;
    if (accept) begin
      case (phase_q)
        PH_SYNC2: begin
          phase_d = (b == SYNC_B) ? PH_SYNC3 : PH_SYNC1;
        end
        PH_SYNC3: begin
          phase_d = (b == SYNC_C) ? PH_HLEN : PH_SYNC1;
        end
        PH_HLEN: begin
          hlen_d = b;
          id_d   = 16'h0;
          len_d  = 16'h0;
          week_d = 16'h0;
          tow_d  = 32'h0;
          case (b)
            8'd0:    crc_d = 32'h0;
            8'd1:    crc_d = CRC_SYNC1;
            8'd2:    crc_d = CRC_SYNC2;
            8'd3:    crc_d = CRC_SYNC3;
            default: crc_d = crc_byte(CRC_SYNC3, b);
          endcase
          cnt_d   = POS_FIRST;
          phase_d = PH_HEADER;
        end
        PH_HEADER: begin
          if (cnt_q >= HDR_LIMIT) begin
            res_valid = 1'b1;
            res_kind  = 1'b1;
            res_stat  = ST_HDR_OVF;
            phase_d   = PH_SYNC1;
          end else begin
            case (cnt_q)
              POS_ID0:  id_d[7:0]    = b;
              POS_ID1:  id_d[15:8]   = b;
              POS_LEN0: len_d[7:0]   = b;
              POS_LEN1: len_d[15:8]  = b;
              POS_WK0:  week_d[7:0]  = b;
              POS_WK1:  week_d[15:8] = b;
              POS_MS0:  tow_d[7:0]   = b;
              POS_MS1:  tow_d[15:8]  = b;
              POS_MS2:  tow_d[23:16] = b;
              POS_MS3:  tow_d[31:24] = b;
              default: ;
            endcase
            if (cnt_q < {8'h00, hlen_q}) begin
              crc_d = crc_byte(crc_q, b);
            end
            cnt_d = cnt_inc;
            if (cnt_inc >= {8'h00, hlen_q}) begin
              cnt_d   = 16'h0;
              phase_d = (len_d == 16'h0) ? PH_CRC1 : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          res_valid = 1'b1;
          if ({1'b0, cnt_q} >= PAY_LIMIT) begin
            res_kind = 1'b1;
            res_stat = ST_PAY_OVF;
            phase_d  = PH_SYNC1;
          end else begin
            crc_d    = crc_byte(crc_q, b);
            res_byte = b;
            res_idx  = cnt_q[7:0];
            cnt_d    = cnt_inc;
            if (cnt_inc >= len_q) begin
              phase_d = PH_CRC1;
            end
          end
        end
        PH_CRC1: begin
          rx_d[7:0] = b;
          phase_d   = PH_CRC2;
        end
        PH_CRC2: begin
          rx_d[15:8] = b;
          phase_d    = PH_CRC3;
        end
        PH_CRC3: begin
          rx_d[23:16] = b;
          phase_d     = PH_CRC4;
        end
        PH_CRC4: begin
          res_valid = 1'b1;
          res_kind  = 1'b1;
          phase_d   = PH_SYNC1;
          if ({b, rx_q} == crc_q) begin
            res_stat = ST_CRC_OK;
          end else begin
            res_stat = ST_CRC_BAD;
            err_d    = err_q + 32'd1;
          end
        end
        default: begin
          phase_d = (b == SYNC_A) ? PH_SYNC2 : PH_SYNC1;
          cnt_d   = 16'h0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SYNC1;
      cnt_q    <= 16'h0;
      hlen_q   <= 8'h00;
      id_q     <= 16'h0;
      len_q    <= 16'h0;
      week_q   <= 16'h0;
      tow_q    <= 32'h0;
      crc_q    <= 32'h0;
      rx_q     <= 24'h0;
      err_q    <= 32'h0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      hlen_q  <= hlen_d;
      id_q    <= id_d;
      len_q   <= len_d;
      week_q  <= week_d;
      tow_q   <= tow_d;
      crc_q   <= crc_d;
      rx_q    <= rx_d;
      err_q   <= err_d;
      if (accept) begin
        ovalid_q <= res_valid;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Report fields are zero for a payload byte.
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      okind_q <= res_kind;
      obyte_q <= res_byte;
      oidx_q  <= res_idx;
      ostat_q <= res_stat;
      oid_q   <= res_kind ? id_q : 16'h0;
      olen_q  <= res_kind ? len_q : 16'h0;
      oweek_q <= res_kind ? week_q : 16'h0;
      otow_q  <= res_kind ? tow_q : 32'h0;
      oerr_q  <= res_kind ? err_d : 32'h0;
    end
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.kind           = okind_q;
  assign out_o.payload_byte   = obyte_q;
  assign out_o.payload_index  = oidx_q;
  assign out_o.status         = ostat_q;
  assign out_o.message_id     = oid_q;
  assign out_o.message_length = olen_q;
  assign out_o.gps_week       = oweek_q;
  assign out_o.gps_ms         = otow_q;
  assign out_o.crc_errors     = oerr_q;
  assign out_o.last           = okind_q;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ovalid_q |-> in_i.ready)
    else $error("Input not ready while the result register is empty.");

  a_header_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> cnt_q <= HDR_LIMIT && cnt_q >= POS_FIRST)
    else $error("Header position outside its range.");

  a_err_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != $past(err_q) |-> err_q == $past(err_q) + 32'd1
                              && $past(phase_q) == PH_CRC4 && $past(accept))
    else $error("CRC error count moved outside a CRC mismatch.");

  a_payload_only_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_valid && !res_kind |-> phase_q == PH_DATA && phase_d != PH_SYNC1)
    else $error("Payload item produced outside the payload phase.");
`endif

endmodule
